// File: rtl/mtg_pkg.sv
package mtg_pkg;

    localparam int unsigned MtN      = 624;
    localparam int unsigned MtM      = 397;
    localparam int unsigned CntW     = 7;
    localparam int unsigned PosW     = 10;
    localparam int unsigned MaxRun   = 64;

    localparam logic [31:0] MtMatrix    = 32'h9908_b0df;
    localparam logic [31:0] MtUpper     = 32'h8000_0000;
    localparam logic [31:0] MtLower     = 32'h7fff_ffff;
    localparam logic [31:0] MtInitMult  = 32'h6c07_8965;
    localparam logic [31:0] MtTemperB   = 32'h9d2c_5680;
    localparam logic [31:0] MtTemperC   = 32'hefc6_0000;
    localparam logic [31:0] MtSeedReset = 32'd5489;

    localparam logic [PosW-1:0] PosLast = PosW'(MtN - 1);
    localparam logic [PosW-1:0] FarWrap = PosW'(MtN - MtM);

    typedef struct packed {
        logic            valid;
        logic [CntW-1:0] count;
    } t_cmd;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & MtTemperB);
        y = y ^ ((y << 15) & MtTemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] v;
        y = (cur & MtUpper) | (nxt & MtLower);
        v = far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ MtMatrix;
        end
        return v;
    endfunction

endpackage

// File: rtl/mtg_front.sv
module mtg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic [mtg_pkg::CntW-1:0]      i_count,
    output mtg_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_pop
);
    import mtg_pkg::*;

    logic [CntW-1:0] r_q [0:1];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [CntW-1:0] w_clamped;
    logic            w_push;

    always_comb begin
        if (i_count > CntW'(MaxRun)) begin
            w_clamped = CntW'(MaxRun);
        end else begin
            w_clamped = i_count;
        end
    end

    assign o_tready    = (r_cnt != 2'd2);
    assign w_push      = i_tvalid && o_tready && (i_count != '0);
    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.count = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/mtg_back.sv
module mtg_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata,
    input  mtg_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_word_valid,
    input  logic                  i_word_ready,
    output logic [31:0]           o_word,
    output logic                  o_word_last
);
    import mtg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_DRAW
    } t_state;

    logic [31:0]     mem [0:MtN-1];

    t_state          r_state;
    logic [31:0]     r_seed;
    logic            r_pending;
    logic [PosW-1:0] r_pos;
    logic [CntW-1:0] r_left;
    logic [PosW-1:0] r_seed_idx;
    logic [31:0]     r_seed_word;
    logic [31:0]     r_cur;
    logic [31:0]     r_rd_nxt;
    logic [31:0]     r_rd_far;
    logic            r_s1_valid;
    logic [PosW-1:0] r_s1_pos;
    logic            r_s1_last;
    logic            r_out_valid;
    logic [31:0]     r_out_word;
    logic            r_out_last;

    logic            w_start;
    logic            w_seed_start;
    logic            w_issue;
    logic            w_s1_adv;
    logic [PosW-1:0] w_addr_nxt;
    logic [PosW-1:0] w_addr_far;
    logic [31:0]     w_twisted;
    logic [31:0]     w_prod;
    logic [31:0]     n_seed_word;
    logic            w_we;
    logic [PosW-1:0] w_waddr;
    logic [31:0]     w_wdata;

    assign w_start      = (r_state == ST_IDLE) && i_cmd.valid && (!r_pending || !r_s1_valid);
    assign w_seed_start = w_start && r_pending;
    assign o_cmd_pop    = w_start;
    assign w_s1_adv     = r_s1_valid && (!r_out_valid || i_word_ready);
    assign w_issue      = (r_state == ST_DRAW) && (!r_s1_valid || w_s1_adv);

    assign w_addr_nxt = (r_pos == PosLast) ? '0 : r_pos + PosW'(1);
    assign w_addr_far = (r_pos < FarWrap) ? r_pos + PosW'(MtM) : r_pos - FarWrap;

    assign w_twisted   = twist_word(r_cur, r_rd_nxt, r_rd_far);
    assign w_prod      = MtInitMult * (r_seed_word ^ (r_seed_word >> 30));
    assign n_seed_word = w_prod + {{(32-PosW){1'b0}}, r_seed_idx};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_seed_idx;
        w_wdata = n_seed_word;
        if (w_s1_adv) begin
            w_we    = 1'b1;
            w_waddr = r_s1_pos;
            w_wdata = w_twisted;
        end else if (w_seed_start) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = r_seed;
        end else if (r_state == ST_SEED) begin
            w_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_nxt <= mem[w_addr_nxt];
            r_rd_far <= mem[w_addr_far];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= MtSeedReset;
            r_pending   <= 1'b1;
            r_pos       <= '0;
            r_left      <= '0;
            r_seed_idx  <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_pos    <= '0;
            r_s1_last   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_left <= i_cmd.count;
                        if (r_pending) begin
                            r_pending   <= 1'b0;
                            r_seed_word <= r_seed;
                            r_cur       <= r_seed;
                            r_seed_idx  <= PosW'(1);
                            r_state     <= ST_SEED;
                        end else begin
                            r_state <= ST_DRAW;
                        end
                    end
                end
                ST_SEED: begin
                    r_seed_word <= n_seed_word;
                    r_seed_idx  <= r_seed_idx + PosW'(1);
                    if (r_seed_idx == PosLast) begin
                        r_pos   <= '0;
                        r_state <= ST_DRAW;
                    end
                end
                ST_DRAW: begin
                    if (w_issue) begin
                        r_s1_pos  <= r_pos;
                        r_s1_last <= (r_left == CntW'(1));
                        r_pos     <= w_addr_nxt;
                        r_left    <= r_left - CntW'(1);
                        if (r_left == CntW'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (w_issue) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_adv) begin
                r_cur       <= r_rd_nxt;
                r_out_word  <= temper(w_twisted);
                r_out_last  <= r_s1_last;
                r_out_valid <= 1'b1;
            end else if (i_word_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_seed    <= i_cfg_wdata;
                r_pending <= 1'b1;
            end
        end
    end

    assign o_word_valid = r_out_valid;
    assign o_word       = r_out_word;
    assign o_word_last  = r_out_last;

endmodule

// File: rtl/mersenne_twister_generator.sv
// Channel    Dir  Signals                              Content
// s_axis     in   tvalid, tready, tdata[7:0]           draw_count in [6:0]
// m_axis     out  tvalid, tready, tdata[31:0], tlast   random_word; tlast = last_of_run
// cfg        in   i_cfg_we, i_cfg_wdata[31:0]          seed
//
// A run of n words leaves at one word per cycle while the output is ready. Its first
// word goes from ST_DRAW through the read registers to the output register, and the
// block idles between runs. The first run after reset or a seed write first fills the
// 624-word state memory on its single write port: the seed, then a multiply-add each.
// Each word is twisted in place when it is drawn, so there is no separate twist pass.
// Reset restores the seed 5489; the state memory has no reset and no clearing pass.
// A stalled output holds the draw pipeline, and a two-entry queue keeps the input open.
module mersenne_twister_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] draw_count, [7] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] random_word
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import mtg_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_pop;

    mtg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_count   (s_axis_tdata[CntW-1:0]),
        .o_cmd     (w_cmd),
        .i_cmd_pop (w_cmd_pop)
    );

    mtg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_word_valid (m_axis_tvalid),
        .i_word_ready (m_axis_tready),
        .o_word       (m_axis_tdata),
        .o_word_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd.valid)
        else $error("run taken from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.valid |-> (w_cmd.count != '0) && (w_cmd.count <= CntW'(MaxRun)))
        else $error("queued run length out of range");

    a_full_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_cmd.valid)
        else $error("input stalled with an empty queue");
`endif

endmodule
